/* rtl/sesa_pkg.sv */
// ----------------------------------------------------------------------------
// Session aggregator package
// Shared item types, codes and defaults for the session aggregator.
// ----------------------------------------------------------------------------
package sesa_pkg;

  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned KeyWidthDefault   = 64;

  localparam int unsigned InKeyW   = 64;
  localparam int unsigned IdW      = 32;
  localparam int unsigned TypeW    = 3;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned OutCntW  = 16;

  localparam int unsigned InFieldsW = InKeyW + IdW + TypeW + TimeW;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutDataW  = InKeyW + 5 * OutCntW + TimeW;

  typedef enum logic [0:0] {
    OP_EVENT = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  typedef enum logic [TypeW-1:0] {
    EV_PING        = 3'd0,
    EV_IMPRESSION  = 3'd1,
    EV_PAGE_VIEW   = 3'd2,
    EV_AD_REQUEST  = 3'd3,
    EV_AD_RESPONSE = 3'd4
  } ev_kind_e;

  typedef struct packed {
    logic [0:0]       opcode;
    logic [InKeyW-1:0] session_key;
    logic [IdW-1:0]   ev_id;
    logic [TypeW-1:0] ev_kind;
    logic [TimeW-1:0] timestamp;
  } item_t;

  typedef struct packed {
    logic [InKeyW-1:0]  group_key;
    logic [OutCntW-1:0] ping_count;
    logic [OutCntW-1:0] impression_count;
    logic [OutCntW-1:0] view_count;
    logic [OutCntW-1:0] ad_request_count;
    logic [OutCntW-1:0] ad_response_count;
    logic [TimeW-1:0]   time_spent;
  } result_t;

endpackage

/* rtl/sesa_in_stage.sv */
// ----------------------------------------------------------------------------
// Session aggregator input stage
// Registers one incoming beat and holds it until the session unit takes it.
// ----------------------------------------------------------------------------
module sesa_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  sesa_pkg::item_t s_item_i,
  output logic           item_valid_o,
  input  logic           item_take_i,
  output sesa_pkg::item_t item_o
);

  logic            valid_q;
  sesa_pkg::item_t item_q;

  assign s_ready_o    = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= s_item_i;
    end
  end

endmodule

/* rtl/sesa_session_unit.sv */
// ----------------------------------------------------------------------------
// Session aggregator session unit
// Holds the open session; folds in one item per cycle unless its result waits.
// ----------------------------------------------------------------------------
module sesa_session_unit #(
  parameter int unsigned COUNT_WIDTH = sesa_pkg::CountWidthDefault,
  parameter int unsigned KEY_WIDTH   = sesa_pkg::KeyWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  sesa_pkg::item_t   item_i,
  output logic              item_take_o,
  input  logic              out_free_i,
  output logic              res_push_o,
  output sesa_pkg::result_t res_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [COUNT_WIDTH-1:0] CountOne = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  logic                           open_q, open_d;
  logic [KEY_WIDTH-1:0]           key_q, key_d;
  logic [sesa_pkg::IdW-1:0]       prev_id_q, prev_id_d;
  logic [sesa_pkg::TimeW-1:0]     start_q, start_d;
  logic [COUNT_WIDTH-1:0]         ping_q, ping_d;
  logic [COUNT_WIDTH-1:0]         impr_q, impr_d;
  logic [COUNT_WIDTH-1:0]         view_q, view_d;
  logic [COUNT_WIDTH-1:0]         adreq_q, adreq_d;
  logic [COUNT_WIDTH-1:0]         adresp_q, adresp_d;
  logic [sesa_pkg::TimeW-1:0]     span_q, span_d;

  logic                           is_flush;
  logic [KEY_WIDTH-1:0]           in_key;
  logic                           new_sess;
  logic                           dup;
  logic                           emit;
  logic [COUNT_WIDTH-1:0]         ping_b, impr_b, view_b, adreq_b, adresp_b;
  logic [sesa_pkg::TimeW-1:0]     span_b, start_b, delta;

  assign is_flush = (item_i.opcode == sesa_pkg::OP_FLUSH);
  assign in_key   = item_i.session_key[KEY_WIDTH-1:0];
  assign new_sess = !open_q || (in_key != key_q);
  assign dup      = !new_sess && (item_i.ev_id == prev_id_q);
  assign emit     = open_q && (is_flush || (in_key != key_q));

  assign item_take_o = item_valid_i && (!emit || out_free_i);
  assign res_push_o  = item_take_o && emit;

  assign ping_b   = new_sess ? '0 : ping_q;
  assign impr_b   = new_sess ? '0 : impr_q;
  assign view_b   = new_sess ? '0 : view_q;
  assign adreq_b  = new_sess ? '0 : adreq_q;
  assign adresp_b = new_sess ? '0 : adresp_q;
  assign span_b   = new_sess ? '0 : span_q;
  assign start_b  = new_sess ? item_i.timestamp : start_q;
  assign delta    = item_i.timestamp - start_b;

  always_comb begin
    open_d    = open_q;
    key_d     = key_q;
    prev_id_d = prev_id_q;
    start_d   = start_q;
    ping_d    = ping_q;
    impr_d    = impr_q;
    view_d    = view_q;
    adreq_d   = adreq_q;
    adresp_d  = adresp_q;
    span_d    = span_q;
    if (item_take_o) begin
      if (is_flush) begin
        open_d = 1'b0;
      end else if (!dup) begin
        open_d    = 1'b1;
        key_d     = in_key;
        start_d   = start_b;
        prev_id_d = item_i.ev_id;
        ping_d    = ping_b;
        impr_d    = impr_b;
        view_d    = view_b;
        adreq_d   = adreq_b;
        adresp_d  = adresp_b;
        span_d    = span_b;
        case (item_i.ev_kind)
          sesa_pkg::EV_PING: begin
            ping_d = (ping_b == CountMax) ? ping_b : ping_b + CountOne;
            if (delta > span_b) begin
              span_d = delta;
            end
          end
          sesa_pkg::EV_IMPRESSION: begin
            impr_d = (impr_b == CountMax) ? impr_b : impr_b + CountOne;
          end
          sesa_pkg::EV_PAGE_VIEW: begin
            view_d = (view_b == CountMax) ? view_b : view_b + CountOne;
          end
          sesa_pkg::EV_AD_REQUEST: begin
            adreq_d = (adreq_b == CountMax) ? adreq_b : adreq_b + CountOne;
          end
          sesa_pkg::EV_AD_RESPONSE: begin
            adresp_d = (adresp_b == CountMax) ? adresp_b : adresp_b + CountOne;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    logic [31:0] w_ping, w_impr, w_view, w_adreq, w_adresp;
    w_ping   = 32'(ping_q);
    w_impr   = 32'(impr_q);
    w_view   = 32'(view_q);
    w_adreq  = 32'(adreq_q);
    w_adresp = 32'(adresp_q);
    res_o.group_key         = sesa_pkg::InKeyW'(key_q);
    res_o.ping_count        = w_ping[sesa_pkg::OutCntW-1:0];
    res_o.impression_count  = w_impr[sesa_pkg::OutCntW-1:0];
    res_o.view_count        = w_view[sesa_pkg::OutCntW-1:0];
    res_o.ad_request_count  = w_adreq[sesa_pkg::OutCntW-1:0];
    res_o.ad_response_count = w_adresp[sesa_pkg::OutCntW-1:0];
    res_o.time_spent        = span_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      key_q     <= '0;
      prev_id_q <= '0;
      start_q   <= '0;
      ping_q    <= '0;
      impr_q    <= '0;
      view_q    <= '0;
      adreq_q   <= '0;
      adresp_q  <= '0;
      span_q    <= '0;
    end else begin
      open_q    <= open_d;
      key_q     <= key_d;
      prev_id_q <= prev_id_d;
      start_q   <= start_d;
      ping_q    <= ping_d;
      impr_q    <= impr_d;
      view_q    <= view_d;
      adreq_q   <= adreq_d;
      adresp_q  <= adresp_d;
      span_q    <= span_d;
    end
  end

endmodule

/* rtl/sesa_out_stage.sv */
// ----------------------------------------------------------------------------
// Session aggregator output stage
// Result register that holds a finished session until the sink takes it.
// ----------------------------------------------------------------------------
module sesa_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sesa_pkg::result_t res_i,
  output logic              free_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output sesa_pkg::result_t m_res_o
);

  logic              valid_q;
  sesa_pkg::result_t res_q;

  assign free_o    = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* rtl/sorted_event_session_aggregator_core.sv */
// ----------------------------------------------------------------------------
// Sorted event session aggregator
// Groups key-sorted events into sessions and emits per-session counts.
//
//   Channel  Direction  Beat carries
//   s_axis   in         one event or a flush (tuser)
//   m_axis   out        one finished session
//
// A beat passes an input register and a result register: a session that a
// beat closes enters the result register when the session unit takes that beat.
// One beat is taken every cycle; the input stalls only while the result register
// is full, the sink does not take it in that cycle, and the registered beat would
// emit a new result. Reset clears the open session and both stage registers.
// ----------------------------------------------------------------------------
module sorted_event_session_aggregator_core #(
  parameter int unsigned COUNT_WIDTH = sesa_pkg::CountWidthDefault,
  parameter int unsigned KEY_WIDTH   = sesa_pkg::KeyWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // session_key, ev_id, ev_kind, timestamp, zero pad
  input  logic [sesa_pkg::InDataW-1:0]  s_axis_tdata_i,
  // opcode
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // group_key, ping_count, impression_count, view_count, ad_request_count,
  // ad_response_count, time_spent
  output logic [sesa_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdLo   = sesa_pkg::InKeyW;
  localparam int unsigned TypeLo = IdLo + sesa_pkg::IdW;
  localparam int unsigned TimeLo = TypeLo + sesa_pkg::TypeW;

  sesa_pkg::item_t   s_item;
  sesa_pkg::item_t   item;
  sesa_pkg::result_t res;
  sesa_pkg::result_t m_res;
  logic              item_valid;
  logic              item_take;
  logic              out_free;
  logic              res_push;

  assign s_item.opcode      = s_axis_tuser_i;
  assign s_item.session_key = s_axis_tdata_i[sesa_pkg::InKeyW-1:0];
  assign s_item.ev_id       = s_axis_tdata_i[TypeLo-1:IdLo];
  assign s_item.ev_kind     = s_axis_tdata_i[TimeLo-1:TypeLo];
  assign s_item.timestamp   = s_axis_tdata_i[TimeLo+sesa_pkg::TimeW-1:TimeLo];

  sesa_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_item_i     (s_item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  sesa_session_unit #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_session (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_free_i   (out_free),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  sesa_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (res_push),
    .res_i     (res),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata_o = {m_res.time_spent, m_res.ad_response_count,
                           m_res.ad_request_count, m_res.view_count,
                           m_res.impression_count, m_res.ping_count,
                           m_res.group_key};

endmodule

/* verif/session_summary_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Session summary checker
// Watches both streams of the session aggregator. It keeps its own copy of the
// open session, works out each summary that an accepted beat closes, and
// compares each accepted summary with the oldest one still due.
// ----------------------------------------------------------------------------
module session_summary_checker #(
  parameter int unsigned COUNT_WIDTH = sesa_pkg::CountWidthDefault,
  parameter int unsigned KEY_WIDTH   = sesa_pkg::KeyWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  logic                          s_ready_i,
  input  logic [sesa_pkg::InDataW-1:0]  s_data_i,
  input  logic                          s_user_i,
  input  logic                          m_valid_i,
  input  logic                          m_ready_i,
  input  logic [sesa_pkg::OutDataW-1:0] m_data_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   summaries_pending_o,
  output int unsigned                   summaries_seen_o
);
  import sesa_pkg::*;

  localparam longint unsigned KeyMask   = {64{1'b1}} >> (64 - KEY_WIDTH);
  localparam longint unsigned CountCeil = {64{1'b1}} >> (64 - COUNT_WIDTH);

  bit                open_q;
  logic [InKeyW-1:0] key_q;
  logic [IdW-1:0]    last_id_q;
  logic [TimeW-1:0]  start_q;
  logic [TimeW-1:0]  span_q;
  longint unsigned   pings_q;
  longint unsigned   impressions_q;
  longint unsigned   views_q;
  longint unsigned   requests_q;
  longint unsigned   responses_q;
  result_t           summaries_due [$];
  int unsigned       mismatches = 0;
  int unsigned       seen = 0;

  function automatic longint unsigned saturating_incr(input longint unsigned count);
    return (count >= CountCeil) ? CountCeil : count + 1;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("summary %0d %s = 0x%0h, expected 0x%0h",
                                seen, name, got, want));
    end
  endtask

  task automatic clear_tallies();
    pings_q       = 0;
    impressions_q = 0;
    views_q       = 0;
    requests_q    = 0;
    responses_q   = 0;
    span_q        = '0;
  endtask

  task automatic close_session();
    result_t summary;
    summary.group_key         = key_q;
    summary.ping_count        = pings_q[OutCntW-1:0];
    summary.impression_count  = impressions_q[OutCntW-1:0];
    summary.view_count        = views_q[OutCntW-1:0];
    summary.ad_request_count  = requests_q[OutCntW-1:0];
    summary.ad_response_count = responses_q[OutCntW-1:0];
    summary.time_spent        = span_q;
    summaries_due.push_back(summary);
  endtask

  task automatic absorb_beat(input item_t beat);
    logic [InKeyW-1:0] key;
    logic [TimeW-1:0]  delta;
    key = beat.session_key & KeyMask;
    if (beat.opcode == OP_FLUSH) begin
      if (open_q) close_session();
      open_q = 1'b0;
    end else if (!(open_q && key == key_q && beat.ev_id == last_id_q)) begin
      if (!open_q || key != key_q) begin
        if (open_q) close_session();
        open_q  = 1'b1;
        key_q   = key;
        start_q = beat.timestamp;
        clear_tallies();
      end
      last_id_q = beat.ev_id;
      delta     = beat.timestamp - start_q;
      case (beat.ev_kind)
        EV_PING: begin
          pings_q = saturating_incr(pings_q);
          if (delta > span_q) span_q = delta;
        end
        EV_IMPRESSION:  impressions_q = saturating_incr(impressions_q);
        EV_PAGE_VIEW:   views_q = saturating_incr(views_q);
        EV_AD_REQUEST:  requests_q = saturating_incr(requests_q);
        EV_AD_RESPONSE: responses_q = saturating_incr(responses_q);
        default: ;
      endcase
    end
  endtask

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    item_t   beat;
    if (!rst_ni) begin
      open_q    = 1'b0;
      key_q     = '0;
      last_id_q = '0;
      start_q   = '0;
      clear_tallies();
      summaries_due.delete();
    end else begin
      if (m_valid_i && m_ready_i) begin
        got.group_key         = m_data_i[0 +: InKeyW];
        got.ping_count        = m_data_i[InKeyW +: OutCntW];
        got.impression_count  = m_data_i[InKeyW + OutCntW +: OutCntW];
        got.view_count        = m_data_i[InKeyW + 2 * OutCntW +: OutCntW];
        got.ad_request_count  = m_data_i[InKeyW + 3 * OutCntW +: OutCntW];
        got.ad_response_count = m_data_i[InKeyW + 4 * OutCntW +: OutCntW];
        got.time_spent        = m_data_i[InKeyW + 5 * OutCntW +: TimeW];
        seen++;
        if (summaries_due.size() == 0) begin
          report_mismatch($sformatf("summary %0d for key 0x%0h arrived with none due",
                                    seen, got.group_key));
        end else begin
          want = summaries_due.pop_front();
          check_field("group_key", got.group_key, want.group_key);
          check_field("ping_count", got.ping_count, want.ping_count);
          check_field("impression_count", got.impression_count, want.impression_count);
          check_field("view_count", got.view_count, want.view_count);
          check_field("ad_request_count", got.ad_request_count, want.ad_request_count);
          check_field("ad_response_count", got.ad_response_count,
                      want.ad_response_count);
          check_field("time_spent", got.time_spent, want.time_spent);
        end
      end
      if (s_valid_i && s_ready_i) begin
        beat.opcode      = s_user_i;
        beat.session_key = s_data_i[0 +: InKeyW];
        beat.ev_id       = s_data_i[InKeyW +: IdW];
        beat.ev_kind     = s_data_i[InKeyW + IdW +: TypeW];
        beat.timestamp   = s_data_i[InKeyW + IdW + TypeW +: TimeW];
        absorb_beat(beat);
      end
    end
    mismatch_count_o    <= mismatches;
    summaries_pending_o <= summaries_due.size();
    summaries_seen_o    <= seen;
  end

endmodule

/* verif/tb_sorted_event_session_aggregator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Session aggregator testbench
// Feeds event and flush beats into the aggregator: a directed opening and a
// long run of randomly shaped sessions. Both sides idle at random and
// the result side stalls once for a long stretch. A separate checker predicts
// and compares every summary.
// ----------------------------------------------------------------------------
module tb_sorted_event_session_aggregator_core;
  import sesa_pkg::*;

  localparam int unsigned     CountWidth       = CountWidthDefault;
  localparam int unsigned     KeyWidth         = KeyWidthDefault;
  localparam int unsigned     RandomEvents     = 1300;
  localparam int unsigned     HoldOffAfter     = 30;
  localparam int unsigned     HoldOffCycles    = 600;
  localparam int unsigned     DrainCycles      = 16;
  localparam longint unsigned CycleLimit       = 2_000_000;
  localparam logic [TypeW-1:0] EvIgnoredLo     = 3'd5;
  localparam logic [TypeW-1:0] EvIgnoredHi     = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                s_valid;
  logic                s_ready;
  logic [InDataW-1:0]  s_data;
  logic                s_user;
  logic                m_valid;
  logic                m_ready;
  logic [OutDataW-1:0] m_data;
  int unsigned         mismatches;
  int unsigned         summaries_pending;
  int unsigned         summaries_seen;
  bit                  sender_calm;
  longint unsigned     beats_sent;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_event_session_aggregator_core #(
    .COUNT_WIDTH(CountWidth),
    .KEY_WIDTH  (KeyWidth)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  session_summary_checker #(
    .COUNT_WIDTH(CountWidth),
    .KEY_WIDTH  (KeyWidth)
  ) checker_inst (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .s_valid_i          (s_valid),
    .s_ready_i          (s_ready),
    .s_data_i           (s_data),
    .s_user_i           (s_user),
    .m_valid_i          (m_valid),
    .m_ready_i          (m_ready),
    .m_data_i           (m_data),
    .mismatch_count_o   (mismatches),
    .summaries_pending_o(summaries_pending),
    .summaries_seen_o   (summaries_seen)
  );

  task automatic offer_beat(input opcode_e op, input logic [InKeyW-1:0] key,
                            input logic [IdW-1:0] id, input logic [TypeW-1:0] kind,
                            input logic [TimeW-1:0] ts);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {{(InDataW - InFieldsW){1'b0}}, ts, kind, id, key};
    do @(posedge clk); while (!s_ready);
    beats_sent++;
  endtask

  initial begin : receiver
    int unsigned wait_cycles;
    int unsigned taken;
    bit          held_off;
    bit          receiver_calm;
    m_ready <= 1'b0;
    taken         = 0;
    held_off      = 1'b0;
    receiver_calm = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) receiver_calm = !receiver_calm;
      wait_cycles = receiver_calm ? 0 : $urandom_range(0, 17);
      if (!held_off && taken >= HoldOffAfter) begin
        wait_cycles = HoldOffCycles;
        held_off    = 1'b1;
      end
      if (wait_cycles != 0) begin
        m_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
      taken++;
    end
  end

  initial begin : watchdog
    longint unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d summaries outstanding.",
             cycles, summaries_pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    longint unsigned  key;
    longint unsigned  returning_key;
    logic [IdW-1:0]   id;
    logic [IdW-1:0]   older_id;
    logic [TimeW-1:0] ts;
    logic [TypeW-1:0] kind;
    int unsigned      len;
    int unsigned      draw;
    int unsigned      events_done;
    rst_n   <= 1'b0;
    s_valid <= 1'b0;
    s_user  <= OP_EVENT;
    s_data  <= '0;
    sender_calm = 1'b0;
    beats_sent  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_beat(OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, EvIgnoredHi, 32'hFFFF_FFFF);
    offer_beat(OP_EVENT, 64'd0, 32'd0, EV_PING, 32'd0);
    offer_beat(OP_EVENT, 64'd0, 32'd0, EV_IMPRESSION, 32'd5);
    offer_beat(OP_EVENT, 64'd0, 32'd1, EV_IMPRESSION, 32'd6);
    offer_beat(OP_EVENT, 64'd0, 32'd2, EV_PAGE_VIEW, 32'd7);
    offer_beat(OP_EVENT, 64'd0, 32'd3, EV_AD_REQUEST, 32'd8);
    offer_beat(OP_EVENT, 64'd0, 32'd4, EV_AD_RESPONSE, 32'd9);
    offer_beat(OP_EVENT, 64'd0, 32'd5, EvIgnoredLo, 32'd10);
    offer_beat(OP_EVENT, 64'd0, 32'd6, EvIgnoredHi, 32'd11);
    offer_beat(OP_EVENT, 64'd0, 32'd6, EV_PING, 32'd12);
    offer_beat(OP_EVENT, 64'd0, 32'd7, EV_PING, 32'hFFFF_FFFF);
    offer_beat(OP_EVENT, 64'd0, 32'd8, EV_PING, 32'd1);
    offer_beat(OP_EVENT, 64'd0, 32'd7, EV_AD_REQUEST, 32'd2);
    offer_beat(OP_EVENT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, EV_PING, 32'hFFFF_FFFF);
    offer_beat(OP_EVENT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, EV_PING, 32'd0);
    offer_beat(OP_FLUSH, 64'd0, 32'd0, EV_PING, 32'd0);
    offer_beat(OP_FLUSH, 64'hA5A5_5A5A_0F0F_F0F0, 32'h1234_5678, EV_PAGE_VIEW, 32'd3);
    offer_beat(OP_EVENT, 64'h8000_0000_0000_0000, 32'd9, EV_AD_RESPONSE, 32'd100);
    offer_beat(OP_EVENT, 64'd1, 32'd9, EV_PING, 32'd50);
    offer_beat(OP_EVENT, 64'h8000_0000_0000_0000, 32'd9, EV_PING, 32'd200);
    offer_beat(OP_FLUSH, 64'd0, 32'd0, EV_PING, 32'd0);

    key           = {$urandom, $urandom};
    returning_key = key;
    events_done   = 0;
    while (events_done < RandomEvents) begin
      draw = $urandom_range(0, 99);
      if (draw < 10) key = {$urandom, $urandom};
      else if (draw < 15) key = returning_key;
      else if (draw >= 30) key = key + $urandom_range(1, 5000);
      if ($urandom_range(0, 7) == 0) returning_key = key;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
      ts       = $urandom;
      id       = $urandom;
      older_id = $urandom;
      for (int j = 0; j < len; j++) begin
        draw = $urandom_range(0, 99);
        if (draw >= 20) begin
          older_id = id;
          id       = (draw < 60) ? id + 1 : $urandom;
        end else if (draw >= 15) begin
          {id, older_id} = {older_id, id};
        end
        kind = ($urandom_range(0, 7) == 0) ? $urandom_range(EvIgnoredLo, EvIgnoredHi)
                                           : $urandom_range(EV_PING, EV_AD_RESPONSE);
        ts = ($urandom_range(0, 15) == 0) ? $urandom : ts + $urandom_range(0, 400);
        offer_beat(OP_EVENT, key, id, kind, ts);
        events_done++;
        if ($urandom_range(0, 49) == 0) begin
          offer_beat(OP_FLUSH, {$urandom, $urandom}, $urandom, $urandom_range(0, 7),
                     $urandom);
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        offer_beat(OP_FLUSH, {$urandom, $urandom}, $urandom, $urandom_range(0, 7), $urandom);
        if ($urandom_range(0, 3) == 0) begin
          offer_beat(OP_FLUSH, {$urandom, $urandom}, $urandom, $urandom_range(0, 7),
                     $urandom);
        end
      end
    end
    offer_beat(OP_FLUSH, 64'd0, 32'd0, EV_PING, 32'd0);

    s_valid <= 1'b0;
    do @(posedge clk); while (summaries_pending != 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d beats of events and flushes; %0d session summaries compared.",
             beats_sent, summaries_seen);
    $display("Both sides idled at random, and the result side stalled once for %0d cycles.",
             HoldOffCycles);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
